FILE: rtl/shortest_remaining_time_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
// All checks are sampled on aclk and disabled while aresetn is low.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH

// Same-cycle implication
`define SRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: rtl/srt_pkg.sv
`default_nettype none

package srt_pkg;

    // Default sizing
    localparam int DEF_MAX_TASKS = 16;
    localparam int DEF_TIME_BITS = 16;

    // Fixed field widths of the stream channels
    localparam int TASK_ID_W  = 4;
    localparam int FIELD_T_W  = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // Operation codes carried on s_tuser
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic wr;   // load an arriving task into this slot
        logic dec;  // this slot won the scan, run it for one unit
    } srt_cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/srt_cell.sv
`default_nettype none

module srt_cell import srt_pkg::*; #(
    parameter int ID_W      = 4,
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int CELL_IDX  = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  srt_cell_ctl_t        ctl,
    input  wire [TIME_BITS-1:0]  wr_burst,
    input  wire [TIME_BITS-1:0]  cur_time,
    // best candidate from the previous cell
    input  wire                  in_valid,
    input  wire [ID_W-1:0]       in_id,
    input  wire [TIME_BITS-1:0]  in_rem,
    input  wire [TIME_BITS-1:0]  in_age,
    input  wire [TIME_BITS-1:0]  in_total,
    // best candidate handed to the next cell
    output logic                 out_valid_reg,
    output logic [ID_W-1:0]      out_id_reg,
    output logic [TIME_BITS-1:0] out_rem_reg,
    output logic [TIME_BITS-1:0] out_age_reg,
    output logic [TIME_BITS-1:0] out_total_reg
);

    logic                 valid_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] total_reg;
    logic [TIME_BITS-1:0] arr_reg;

    logic [TIME_BITS-1:0] own_age;
    logic                 take_own;
    logic                 load;

    // Own task beats the incoming one on less remaining time, then on larger age
    always_comb begin
        own_age  = cur_time - arr_reg;
        take_own = valid_reg &&
                   (!in_valid || (rem_reg < in_rem) ||
                    ((rem_reg == in_rem) && (own_age > in_age)));
        load     = ctl.wr && !valid_reg;
    end

    // Slot occupancy and candidate valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
            end else if (ctl.dec && valid_reg && (rem_reg == TIME_BITS'(1))) begin
                valid_reg <= 1'b0;
            end
            out_valid_reg <= take_own || in_valid;
        end
    end

    // Slot payload and candidate payload
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg   <= wr_burst;
            total_reg <= wr_burst;
            arr_reg   <= cur_time;
        end else if (ctl.dec && valid_reg) begin
            rem_reg <= rem_reg - TIME_BITS'(1);
        end
        if (take_own) begin
            out_id_reg    <= ID_W'(CELL_IDX);
            out_rem_reg   <= rem_reg;
            out_age_reg   <= own_age;
            out_total_reg <= total_reg;
        end else begin
            out_id_reg    <= in_id;
            out_rem_reg   <= in_rem;
            out_age_reg   <= in_age;
            out_total_reg <= in_total;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shortest_remaining_time_scheduler.sv
// Arrive transfer: no result, next transfer accepted in the following cycle.
// Tick transfer: no further input is accepted from acceptance until the apply step completes;
//   the pick walks a chain of MAX_TASKS compare cells, one cell per cycle.
// A finishing tick presents its result on the cycle after the apply step; a held result
//   stalls only the apply step of the following finishing tick.
// Reset (aresetn low, synchronous): all slots free, clock at zero, no result pending.
`default_nettype none

`include "shortest_remaining_time_scheduler_assert.svh"

module shortest_remaining_time_scheduler import srt_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_TDATA_W-1:0]  s_tdata,   // [3:0] task_id, [19:4] burst_time, [23:20] zero
    input  wire                  s_tuser,   // [0] operation
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [3:0] finished_task, [19:4] turnaround_time,
                                            // [35:20] waiting_time, [39:36] zero
);

    localparam int ID_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t                state_reg, state_next;
    logic [ID_W-1:0]       cnt_reg;
    logic [TIME_BITS-1:0]  cur_time_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [TASK_ID_W-1:0]  in_task_id;
    logic [TIME_BITS-1:0]  in_burst;
    logic                  s_xfer;
    logic                  arrive_ok;
    logic                  finish;
    logic                  apply_go;
    logic [TIME_BITS-1:0]  tat;
    logic [TIME_BITS-1:0]  wt;
    logic [31:0]           win_id_wide;
    logic [MAX_TASKS-1:0]  dec_vec;

    // Candidate chain, entry 0 is the empty candidate
    logic                  ch_valid [MAX_TASKS+1];
    logic [ID_W-1:0]       ch_id    [MAX_TASKS+1];
    logic [TIME_BITS-1:0]  ch_rem   [MAX_TASKS+1];
    logic [TIME_BITS-1:0]  ch_age   [MAX_TASKS+1];
    logic [TIME_BITS-1:0]  ch_total [MAX_TASKS+1];

    srt_cell_ctl_t         cell_ctl [MAX_TASKS];

    assign ch_valid[0] = 1'b0;
    assign ch_id[0]    = '0;
    assign ch_rem[0]   = '0;
    assign ch_age[0]   = '0;
    assign ch_total[0] = '0;

    // Input fields
    assign in_task_id = s_tdata[3:0];
    assign in_burst   = TIME_BITS'(s_tdata[19:4]);
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign arrive_ok  = s_xfer && (s_tuser == OP_ARRIVE) && (in_burst != '0);

    // Winner at the end of the chain
    assign finish      = ch_valid[MAX_TASKS] && (ch_rem[MAX_TASKS] == TIME_BITS'(1));
    assign apply_go    = (state_reg == ST_APPLY) && !(finish && m_tvalid_reg && !m_tready);
    assign tat         = ch_age[MAX_TASKS] + TIME_BITS'(1);
    assign wt          = tat - ch_total[MAX_TASKS];
    assign win_id_wide = 32'(ch_id[MAX_TASKS]);

    // Row of slot cells
    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        assign dec_vec[i]      = apply_go && ch_valid[MAX_TASKS] &&
                                 (ch_id[MAX_TASKS] == ID_W'(i));
        assign cell_ctl[i].wr  = arrive_ok && (32'(in_task_id) == 32'(i));
        assign cell_ctl[i].dec = dec_vec[i];

        srt_cell #(
            .ID_W      (ID_W),
            .TIME_BITS (TIME_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (cell_ctl[i]),
            .wr_burst      (in_burst),
            .cur_time      (cur_time_reg),
            .in_valid      (ch_valid[i]),
            .in_id         (ch_id[i]),
            .in_rem        (ch_rem[i]),
            .in_age        (ch_age[i]),
            .in_total      (ch_total[i]),
            .out_valid_reg (ch_valid[i+1]),
            .out_id_reg    (ch_id[i+1]),
            .out_rem_reg   (ch_rem[i+1]),
            .out_age_reg   (ch_age[i+1]),
            .out_total_reg (ch_total[i+1])
        );
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_tuser == OP_TICK)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == ID_W'(MAX_TASKS - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, clock and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cur_time_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + ID_W'(1);
            end else begin
                cnt_reg <= '0;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (apply_go) begin
                cur_time_reg <= cur_time_reg + TIME_BITS'(1);
                if (finish) begin
                    m_tvalid_reg <= 1'b1;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (apply_go && finish) begin
            m_tdata_reg <= {4'b0000, 16'(wt), 16'(tat), win_id_wide[3:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `SRT_ASSERT_NEXT(a_tick_busy, s_xfer && (s_tuser == OP_TICK), !s_tready)
    `SRT_ASSERT_NOW(a_one_dec, 1'b1, $onehot0(dec_vec))
    `SRT_ASSERT_NEXT(a_time_step, apply_go, cur_time_reg == $past(cur_time_reg) + TIME_BITS'(1))
    `SRT_ASSERT_NOW(a_result_src, $rose(m_tvalid_reg), $past(state_reg == ST_APPLY))

endmodule

`default_nettype wire

FILE: verif/tb_shortest_remaining_time_scheduler.sv
`timescale 1ns / 1ps

// One completed task as seen on the result stream
typedef struct {
    logic [3:0]  slot;
    logic [15:0] turnaround;
    logic [15:0] waiting;
} completion_t;

// Tracks the scheduler's slots and clock, predicts completions, checks results
class srt_scoreboard;
    bit          occupied [srt_pkg::DEF_MAX_TASKS];
    bit [15:0]   left     [srt_pkg::DEF_MAX_TASKS];
    bit [15:0]   total    [srt_pkg::DEF_MAX_TASKS];
    bit [15:0]   stamp    [srt_pkg::DEF_MAX_TASKS];
    bit [15:0]   now;
    completion_t completions [$];
    int          errors;

    function new();
        now    = '0;
        errors = 0;
        foreach (occupied[i]) begin
            occupied[i] = 1'b0;
        end
    endfunction

    // Apply one accepted input transfer; returns 0 if the block ignores it
    function bit note_transfer(logic op, logic [3:0] id, logic [15:0] burst);
        int          pick;
        bit [15:0]   age_i;
        bit [15:0]   age_p;
        completion_t done_rec;
        pick = -1;
        if (op == srt_pkg::OP_ARRIVE) begin
            // occupied slot or zero burst: dropped
            if (occupied[id] || burst == 16'd0) begin
                return 1'b0;
            end
            occupied[id] = 1'b1;
            left[id]     = burst;
            total[id]    = burst;
            stamp[id]    = now;
            return 1'b1;
        end
        // pick least remaining, then oldest by wrapped age, then lowest slot
        for (int i = 0; i < srt_pkg::DEF_MAX_TASKS; i++) begin
            if (occupied[i]) begin
                if (pick < 0) begin
                    pick = i;
                end else if (left[i] < left[pick]) begin
                    pick = i;
                end else if (left[i] == left[pick]) begin
                    age_i = now - stamp[i];
                    age_p = now - stamp[pick];
                    if (age_i > age_p) begin
                        pick = i;
                    end
                end
            end
        end
        now = now + 16'd1;
        if (pick >= 0) begin
            left[pick] = left[pick] - 16'd1;
            if (left[pick] == 16'd0) begin
                occupied[pick]      = 1'b0;
                done_rec.slot       = pick[3:0];
                done_rec.turnaround = now - stamp[pick];
                done_rec.waiting    = done_rec.turnaround - total[pick];
                completions.push_back(done_rec);
            end
        end
        return 1'b1;
    endfunction

    // Compare one result transfer with the oldest predicted completion
    function void check_result(logic [srt_pkg::M_TDATA_W-1:0] data);
        completion_t want;
        logic [3:0]  got_slot;
        logic [15:0] got_tat;
        logic [15:0] got_wt;
        got_slot = data[3:0];
        got_tat  = data[19:4];
        got_wt   = data[35:20];
        if (completions.size() == 0) begin
            $display("%0t: unexpected result: slot %0d turnaround %0d waiting %0d",
                     $time, got_slot, got_tat, got_wt);
            errors++;
            return;
        end
        want = completions.pop_front();
        if (got_slot !== want.slot) begin
            $display("%0t: finished_task mismatch: expected %0d, actual %0d",
                     $time, want.slot, got_slot);
            errors++;
        end
        if (got_tat !== want.turnaround) begin
            $display("%0t: turnaround_time mismatch: expected %0d, actual %0d",
                     $time, want.turnaround, got_tat);
            errors++;
        end
        if (got_wt !== want.waiting) begin
            $display("%0t: waiting_time mismatch: expected %0d, actual %0d",
                     $time, want.waiting, got_wt);
            errors++;
        end
    endfunction

    function int pending();
        return completions.size();
    endfunction

    function int busy_count();
        int n;
        n = 0;
        foreach (occupied[i]) begin
            if (occupied[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // First free slot at or after start (cyclic), or -1 when all are taken
    function int free_slot(int start);
        int k;
        for (int i = 0; i < srt_pkg::DEF_MAX_TASKS; i++) begin
            k = (start + i) % srt_pkg::DEF_MAX_TASKS;
            if (!occupied[k]) begin
                return k;
            end
        end
        return -1;
    endfunction
endclass

module tb_shortest_remaining_time_scheduler;
    import srt_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int TICK_CYCLES  = DEF_MAX_TASKS + 2;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 385;
    localparam longint CYCLE_LIMIT = 5_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = OP_ARRIVE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_asks      = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;
    longint cycle_count    = 0;

    srt_scoreboard sb;

    shortest_remaining_time_scheduler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_shortest_remaining_time_scheduler failed");
            $finish;
        end
    end

    // Result side: check transfers, random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_seen != hold_asks) begin
                hold_seen <= hold_asks;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item and wait for its transfer; valid stays up afterwards
    task automatic send_item(input logic op, input logic [3:0] id,
                             input logic [15:0] burst, output bit took);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, burst, id};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        took = sb.note_transfer(op, id, burst);
    endtask

    task automatic send_tick();
        bit took;
        send_item(OP_TICK, 4'($urandom_range(15)), 16'($urandom), took);
    endtask

    // Sender holds back until every predicted completion has been seen
    task automatic drain_results();
        if (sb.pending() != 0) begin
            s_tvalid <= 1'b0;
            while (sb.pending() != 0) begin
                @(posedge aclk);
            end
        end
    endtask

    // Random traffic: arrivals get likelier as slots free up
    task automatic run_random(input int items);
        int          counted;
        int          pick;
        int          slot;
        bit          took;
        logic [3:0]  id;
        logic [15:0] burst;
        counted = 0;
        while (counted < items) begin
            if ($urandom_range(99) == 0) begin
                drain_results();
            end
            if ($urandom_range(15) >= sb.busy_count() || $urandom_range(9) == 0) begin
                slot = sb.free_slot($urandom_range(15));
                if (slot < 0 || $urandom_range(4) == 0) begin
                    id = 4'($urandom_range(15));
                end else begin
                    id = 4'(slot);
                end
                pick = $urandom_range(99);
                if (pick < 2) begin
                    burst = 16'd0;
                end else if (pick < 85) begin
                    burst = 16'($urandom_range(8, 1));
                end else if (pick < 98) begin
                    burst = 16'($urandom_range(64, 9));
                end else begin
                    burst = 16'($urandom);
                end
                send_item(OP_ARRIVE, id, burst, took);
            end else begin
                send_item(OP_TICK, 4'($urandom_range(15)), 16'($urandom), took);
            end
            counted++;
        end
    endtask

    initial begin
        bit took;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, one-unit task, zero burst, occupied slot, ties
        send_tick();
        send_item(OP_ARRIVE, 4'd0, 16'd1, took);
        send_tick();
        send_item(OP_ARRIVE, 4'd4, 16'd0, took);
        send_tick();
        send_item(OP_ARRIVE, 4'd9, 16'd4, took);
        send_tick();
        // equal remaining: older task in slot 9 beats slot 3
        send_item(OP_ARRIVE, 4'd3, 16'd3, took);
        send_item(OP_ARRIVE, 4'd3, 16'd7, took);
        // same stamp and remaining: slot 6 before slot 12
        send_item(OP_ARRIVE, 4'd12, 16'd2, took);
        send_item(OP_ARRIVE, 4'd6, 16'd2, took);
        repeat (10) send_tick();
        while (sb.busy_count() != 0) begin
            send_tick();
        end
        drain_results();

        // No idling, with a long receiver hold-off at the start
        hold_asks <= hold_asks + 1;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 27;
        recv_stall_pct = 27;
        run_random(PHASE_ITEMS);
        drain_results();

        s_tvalid <= 1'b0;
        repeat (4 * TICK_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_shortest_remaining_time_scheduler passed");
        end else begin
            $display("tb_shortest_remaining_time_scheduler failed");
        end
        $finish;
    end
endmodule
